>>> rtl/sha_pkg.sv
// Shared types and constants for the slot handle allocator.
// Used by slot_handle_allocator, handle_grant_checker and the testbench; no dependencies.
package sha_pkg;

  localparam int SlotCount = 256;
  localparam int IdxW      = $clog2(SlotCount);
  localparam int HandleW   = IdxW + 1;
  localparam int AddrW     = 32;

  // Slot count at handle width, for compares against the counters.
  localparam logic [HandleW-1:0] SlotCountH = HandleW'(SlotCount);

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_QUERY  = 2'd2
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [AddrW-1:0]   target_address;
    logic [HandleW-1:0] handle_in;
    logic               patch_ok;
  } req_t;

  typedef struct packed {
    logic [HandleW-1:0] handle_out;
    logic               success;
  } rsp_t;

endpackage

>>> rtl/sha_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/slot_handle_allocator.sv
// Slot handle allocator: top level with slot valid bits, LIFO free stack
// and result register. Depends on sha_pkg and sha_ram.
//
// Usage:
//   Request channel (req_valid / req_stall / req) carries one operation per
//   transaction: add, remove or query. Response channel (rsp_valid /
//   rsp_stall / rsp) returns exactly one result per request, in order.
//   A request taken at a clock edge has its response registered at that
//   same edge and visible until the receiver takes it.
//   Throughput is one request per cycle unless stalled; each request reads
//   the stack top register, one slot valid bit and the high-water mark, and
//   the prefetched entry below the stack top comes from the free stack RAM.
//   The request side stalls only while a response is held against a
//   stall, so the result register parts the two sides.
//   Reset clears all slot valid bits, the free count and the high-water
//   mark; the free stack RAM needs no clearing since only entries below
//   the free count are read. No clearing pass, ready right after reset.
//   Handles are 1-based; handle 0 means "no slot". Target addresses are
//   accepted but no stored value is ever reported, so none is retained.
module slot_handle_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sha_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sha_pkg::rsp_t rsp
);

  localparam int IdxW    = sha_pkg::IdxW;
  localparam int HandleW = sha_pkg::HandleW;

  logic                 accept;
  logic [sha_pkg::SlotCount-1:0] slot_valid;
  logic [HandleW-1:0]   free_count, free_count_next;
  logic [HandleW-1:0]   high_water, high_water_next;
  logic [IdxW-1:0]      stack_top, stack_top_next;
  logic [IdxW-1:0]      below_bypass;
  logic                 below_sel;
  logic [IdxW-1:0]      ram_q;
  logic [IdxW-1:0]      below;
  logic [IdxW-1:0]      handle_idx;
  logic                 handle_hit, slot_hit;
  logic                 push, pop;
  logic                 set_valid, clr_valid;
  logic [IdxW-1:0]      grant_idx;
  logic                 ram_we;
  logic [IdxW-1:0]      ram_waddr, ram_raddr;
  logic [HandleW-1:0]   waddr_wide, raddr_wide;
  sha_pkg::rsp_t        result;

  // Hold the request side only while a response waits against a stall.
  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;

  // Entry just below the stack top: after a push it is the old top (the
  // RAM write and the prefetch hit the same address), else the RAM data.
  assign below = below_sel ? below_bypass : ram_q;

  // Decode the handle: nonzero and within the slots ever taken.
  assign handle_idx = req.handle_in[IdxW-1:0] - IdxW'(1);
  assign handle_hit = (req.handle_in != '0) && (req.handle_in <= high_water);
  assign slot_hit   = handle_hit && slot_valid[handle_idx];

  always_comb begin
    push            = 1'b0;
    pop             = 1'b0;
    set_valid       = 1'b0;
    clr_valid       = 1'b0;
    grant_idx       = stack_top;
    high_water_next = high_water;
    result          = '0;
    if (accept) begin
      unique case (req.func)
        sha_pkg::FUNC_ADD: begin
          if (free_count != '0) begin
            // Reuse the most recently freed slot; a failed patch leaves it
            // on the stack untouched.
            grant_idx = stack_top;
            if (req.patch_ok) begin
              pop       = 1'b1;
              set_valid = 1'b1;
            end
          end else if (high_water != sha_pkg::SlotCountH) begin
            // Take a fresh slot and raise the high-water mark.
            grant_idx = high_water[IdxW-1:0];
            if (req.patch_ok) begin
              set_valid       = 1'b1;
              high_water_next = high_water + HandleW'(1);
            end
          end
          if (set_valid) begin
            result.handle_out = {1'b0, grant_idx} + HandleW'(1);
            result.success    = 1'b1;
          end
        end
        sha_pkg::FUNC_REMOVE: begin
          if (slot_hit) begin
            clr_valid      = 1'b1;
            push           = (free_count != sha_pkg::SlotCountH);
            result.success = 1'b1;
          end
        end
        sha_pkg::FUNC_QUERY: begin
          result.success = slot_hit;
        end
        default: begin
          // Unused code: no operation, empty result.
        end
      endcase
    end
  end

  always_comb begin
    free_count_next = free_count;
    stack_top_next  = stack_top;
    if (push) begin
      free_count_next = free_count + HandleW'(1);
      stack_top_next  = handle_idx;
    end else if (pop) begin
      free_count_next = free_count - HandleW'(1);
      stack_top_next  = below;
    end
  end

  // Spill the old top into the RAM on a push over a nonempty stack, and
  // prefetch the entry that will sit below the new top.
  assign waddr_wide = free_count - HandleW'(1);
  assign raddr_wide = free_count_next - HandleW'(2);
  assign ram_we     = push && (free_count != '0);
  assign ram_waddr  = waddr_wide[IdxW-1:0];
  assign ram_raddr  = raddr_wide[IdxW-1:0];

  sha_ram #(
    .WIDTH (IdxW),
    .DEPTH (sha_pkg::SlotCount)
  ) u_free_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (stack_top),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= '0;
      high_water <= '0;
      below_sel  <= 1'b0;
      slot_valid <= '0;
    end else begin
      free_count <= free_count_next;
      high_water <= high_water_next;
      below_sel  <= push;
      if (set_valid) begin
        slot_valid[grant_idx] <= 1'b1;
      end
      if (clr_valid) begin
        slot_valid[handle_idx] <= 1'b0;
      end
    end
  end

  // Stack payload registers: meaningful only below the free count.
  always_ff @(posedge clk) begin
    stack_top    <= stack_top_next;
    below_bypass <= stack_top;
  end

  // Result register: load on accept, drop once the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= result;
    end
  end

  // Every slot on the free stack was once taken.
  a_free_le_hw: assert property (@(posedge clk) disable iff (rst)
    free_count <= high_water)
    else $error("free count exceeds high-water mark");

  a_hw_range: assert property (@(posedge clk) disable iff (rst)
    high_water <= sha_pkg::SlotCountH)
    else $error("high-water mark beyond slot count");

  a_handle_success: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.handle_out != '0) |-> rsp.success)
    else $error("handle granted without success");

  // A full table refuses every add.
  a_full_add: assert property (@(posedge clk) disable iff (rst)
    accept && (req.func == sha_pkg::FUNC_ADD) && (free_count == '0) &&
    (high_water == sha_pkg::SlotCountH) |=> (rsp.handle_out == '0) && !rsp.success)
    else $error("add granted on full table");

endmodule

>>> test/handle_grant_checker.sv
`timescale 1ns / 100ps
// Checker for the slot handle allocator: watches both channels, keeps its own
// copy of the slot table and free stack, and compares responses in order.
// Depends on sha_pkg.
module handle_grant_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  sha_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  sha_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending
);

  localparam int ReportMax = 10;

  logic                    slot_live [sha_pkg::SlotCount];
  logic [sha_pkg::IdxW-1:0] free_lifo [sha_pkg::SlotCount];
  int                      free_depth = 0;
  int                      taken_mark = 0;
  sha_pkg::rsp_t           expected_grants [$];
  int                      fails = 0;

  // Apply one operation to the table copy and return the response it yields.
  function automatic sha_pkg::rsp_t apply_table_op(input sha_pkg::req_t r);
    sha_pkg::rsp_t res;
    int            named;
    int            slot;
    res   = '0;
    slot  = -1;
    named = (r.handle_in == 0 || r.handle_in > taken_mark) ? -1 : int'(r.handle_in) - 1;
    case (r.func)
      sha_pkg::FUNC_ADD: begin
        if (free_depth > 0) begin
          // a rejected patch leaves the reused slot on top of the stack
          if (r.patch_ok) begin
            free_depth--;
            slot = int'(free_lifo[free_depth]);
          end
        end else if (taken_mark < sha_pkg::SlotCount) begin
          if (r.patch_ok) begin
            slot = taken_mark;
            taken_mark++;
          end
        end
        if (slot >= 0) begin
          slot_live[slot] = 1'b1;
          res.handle_out  = sha_pkg::HandleW'(slot + 1);
          res.success     = 1'b1;
        end
      end
      sha_pkg::FUNC_REMOVE: begin
        if (named >= 0 && slot_live[named]) begin
          slot_live[named] = 1'b0;
          if (free_depth < sha_pkg::SlotCount) begin
            free_lifo[free_depth] = named[sha_pkg::IdxW-1:0];
            free_depth++;
          end
          res.success = 1'b1;
        end
      end
      sha_pkg::FUNC_QUERY: begin
        if (named >= 0 && slot_live[named])
          res.success = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : track
    sha_pkg::rsp_t want;
    if (rst) begin
      for (int i = 0; i < sha_pkg::SlotCount; i++) slot_live[i] = 1'b0;
      free_depth = 0;
      taken_mark = 0;
      expected_grants.delete();
    end else begin
      // check the response first: a request taken at this edge answers later
      if (rsp_valid && !rsp_stall) begin
        if (expected_grants.size() == 0) begin
          fails++;
          if (fails <= ReportMax)
            $display("%0t: response with none expected: handle_out=%0d success=%0b",
                     $realtime, rsp.handle_out, rsp.success);
        end else begin
          want = expected_grants.pop_front();
          if (rsp.handle_out !== want.handle_out || rsp.success !== want.success) begin
            fails++;
            if (fails <= ReportMax)
              $display("%0t: mismatch: expected handle_out=%0d success=%0b, got %0d %0b",
                       $realtime, want.handle_out, want.success, rsp.handle_out,
                       rsp.success);
          end
        end
      end
      if (req_valid && !req_stall)
        expected_grants.insert(expected_grants.size(), apply_table_op(req));
    end
    fail_count <= fails;
    pending    <= expected_grants.size();
  end

endmodule

>>> test/tb_slot_handle_allocator.sv
`timescale 1ns / 100ps
// Testbench top for slot_handle_allocator: drives request transactions and
// response stalls, and gives the verdict. Depends on sha_pkg, the block and
// handle_grant_checker.
module tb_slot_handle_allocator;

  // The spare func code: the block must answer it as a no-op.
  localparam sha_pkg::func_t FuncSpare = sha_pkg::func_t'(2'd3);
  localparam int    WatchdogLimit = 2000;
  localparam int    GapMax        = 24;
  localparam int    DrainCycles   = 4;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  sha_pkg::req_t req;
  logic rsp_valid;
  logic rsp_stall;
  sha_pkg::rsp_t rsp;

  int fail_count;
  int pending;
  int send_pct  = 0;   // chance per transaction of the sender idling, redrawn to extend the gap
  int stall_pct = 0;   // chance per cycle of the receiver stalling
  int quiet_cycles = 0;
  int unsigned release_order [sha_pkg::SlotCount];

  slot_handle_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  handle_grant_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver side: stall at random, one decision per cycle at the falling edge.
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: end the run if no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one request transaction. Called at a falling edge; returns at the
  // falling edge after acceptance with valid still high, so back-to-back
  // transactions never lower and raise valid in one step.
  task automatic send_op(input sha_pkg::req_t r);
    int gap;
    gap = 0;
    while (gap < GapMax && $urandom_range(99) < send_pct) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    // hold the payload until the block takes it
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic post_op(input sha_pkg::func_t f, input int unsigned h, input logic ok,
                         input logic [sha_pkg::AddrW-1:0] addr);
    sha_pkg::req_t r;
    r.func           = f;
    r.target_address = addr;
    r.handle_in      = sha_pkg::HandleW'(h);
    r.patch_ok       = ok;
    send_op(r);
  endtask

  // Drop valid and hold off until every outstanding response has come back.
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Random operation with the given add/remove/query weights in percent; the
  // rest goes to the spare code. Handles mostly name real slots, with some
  // zero and some beyond the table to reach the top handle bit.
  function automatic sha_pkg::req_t random_op(input int add_w, input int rem_w,
                                              input int qry_w);
    sha_pkg::req_t r;
    int   roll;
    int   pick;
    roll = $urandom_range(99);
    if (roll < add_w)                       r.func = sha_pkg::FUNC_ADD;
    else if (roll < add_w + rem_w)          r.func = sha_pkg::FUNC_REMOVE;
    else if (roll < add_w + rem_w + qry_w)  r.func = sha_pkg::FUNC_QUERY;
    else                                    r.func = FuncSpare;
    pick = $urandom_range(99);
    if (pick < 4)        r.handle_in = '0;
    else if (pick < 10)  r.handle_in = sha_pkg::HandleW'($urandom_range(511,
                                                          sha_pkg::SlotCount + 1));
    else                 r.handle_in = sha_pkg::HandleW'($urandom_range(sha_pkg::SlotCount,
                                                                        1));
    pick = $urandom_range(99);
    if (pick < 3)        r.target_address = '0;
    else if (pick < 6)   r.target_address = '1;
    else                 r.target_address = $urandom;
    r.patch_ok = ($urandom_range(99) < 85);
    return r;
  endfunction

  task automatic run_mix(input int count, input int add_w, input int rem_w,
                         input int qry_w);
    repeat (count) send_op(random_op(add_w, rem_w, qry_w));
  endtask

  initial begin
    int unsigned j;
    int unsigned tmp;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;

    // Phase one: sender mostly busy, receiver stalls heavily.
    send_pct  = 13;
    stall_pct = 75;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty-table lookups, rejected patch on a fresh slot,
    // address extremes, handles past the high-water mark and past the table.
    post_op(sha_pkg::FUNC_QUERY,  0,   1'b1, 32'h0);
    post_op(sha_pkg::FUNC_REMOVE, 1,   1'b1, 32'h0);
    post_op(sha_pkg::FUNC_ADD,    0,   1'b0, 32'h1234_5678);
    post_op(sha_pkg::FUNC_ADD,    0,   1'b1, 32'h0000_0000);
    post_op(sha_pkg::FUNC_ADD,    511, 1'b1, 32'hFFFF_FFFF);
    post_op(sha_pkg::FUNC_QUERY,  1,   1'b0, 32'h0);
    post_op(sha_pkg::FUNC_QUERY,  2,   1'b1, 32'h0);
    post_op(sha_pkg::FUNC_QUERY,  3,   1'b1, 32'h0);
    post_op(sha_pkg::FUNC_QUERY,  256, 1'b1, 32'h0);
    post_op(sha_pkg::FUNC_QUERY,  511, 1'b1, 32'hFFFF_FFFF);
    // Remove, then remove the now-invalid slot again.
    post_op(sha_pkg::FUNC_REMOVE, 1,   1'b1, 32'h0);
    post_op(sha_pkg::FUNC_REMOVE, 1,   1'b1, 32'h0);
    post_op(sha_pkg::FUNC_QUERY,  1,   1'b1, 32'h0);
    // Rejected patch on a reused slot must leave it on the stack.
    post_op(sha_pkg::FUNC_ADD,    0,   1'b0, 32'hA5A5_A5A5);
    post_op(sha_pkg::FUNC_ADD,    0,   1'b1, 32'h5A5A_5A5A);
    post_op(FuncSpare,            1,   1'b1, 32'hFFFF_FFFF);
    post_op(sha_pkg::FUNC_REMOVE, 0,   1'b1, 32'h0);
    post_op(sha_pkg::FUNC_REMOVE, 511, 1'b1, 32'h0);
    // Two frees, then two adds: LIFO order gives them back reversed.
    post_op(sha_pkg::FUNC_REMOVE, 2,   1'b1, 32'h0);
    post_op(sha_pkg::FUNC_REMOVE, 1,   1'b1, 32'h0);
    post_op(sha_pkg::FUNC_ADD,    0,   1'b1, 32'h0000_0001);
    post_op(sha_pkg::FUNC_ADD,    0,   1'b1, 32'h8000_0000);

    // Fill the table and keep adding past full, including rejected patches.
    repeat (300) post_op(sha_pkg::FUNC_ADD, $urandom_range(511, 0),
                         ($urandom_range(99) < 95), $urandom);
    wait_idle();

    // Phase two: sender idles heavily, receiver stalls rarely.
    send_pct  = 75;
    stall_pct = 13;
    // Release every slot in shuffled order to churn the free stack.
    for (int i = 0; i < sha_pkg::SlotCount; i++) release_order[i] = i + 1;
    for (int i = sha_pkg::SlotCount - 1; i > 0; i--) begin
      j                = $urandom_range(i, 0);
      tmp              = release_order[i];
      release_order[i] = release_order[j];
      release_order[j] = tmp;
    end
    for (int i = 0; i < sha_pkg::SlotCount; i++)
      post_op(sha_pkg::FUNC_REMOVE, release_order[i], 1'($urandom_range(1, 0)), $urandom);
    run_mix(250, 45, 35, 15);
    wait_idle();

    // Phase three: no idling on either side. Grow, churn, then shrink.
    send_pct  = 0;
    stall_pct = 0;
    run_mix(220, 80, 5, 10);
    run_mix(150, 35, 40, 20);
    run_mix(150, 15, 60, 20);
    wait_idle();
    repeat (DrainCycles) @(negedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
